FILE: hdl/lfr_pkg.sv
// Shared types and constants for the lidar frame receiver.
package lfr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'h59;
    localparam logic [7:0] HDR_SUM  = 8'hB2;

    localparam logic [7:0] MAX_SKIP_RESET    = 8'd30;
    localparam logic [7:0] MAX_RETRIES_RESET = 8'd10;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKIP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'b1;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_NO_HEADER = 2'd1;
    localparam logic [1:0] FAULT_CHECKSUM  = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_GAVE_UP = 1'b1;

    typedef struct packed {
        logic [7:0] max_skip_bytes;
        logic [7:0] max_retries;
    } lfr_cfg_t;

    typedef struct packed {
        logic        status;
        logic [15:0] range_value;
        logic [15:0] signal_level;
        logic [1:0]  last_fault;
    } lfr_result_t;

endpackage

FILE: hdl/lfr_if.sv
// Valid/ready channel interfaces for received bytes and measurement results.
interface lfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfr_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] range_value;
    logic [15:0] signal_level;
    logic [1:0]  last_fault;

    modport source (output valid, output status, output range_value,
                    output signal_level, output last_fault, input ready);
    modport sink (input valid, input status, input range_value,
                  input signal_level, input last_fault, output ready);
endinterface

FILE: hdl/lfr_parser.sv
// Frame hunt, checksum and retry state; one byte processed per step.
module lfr_parser #(
    parameter int FRAME_LEN = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  lfr_pkg::lfr_cfg_t   cfg,
    output logic                res_valid,
    output lfr_pkg::lfr_result_t res
);
    import lfr_pkg::*;

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] NUM_PAYLOAD = POS_W'(4);

    logic             in_frame_reg, in_frame_next;
    logic [7:0]       prev_byte_reg, prev_byte_next;
    logic [8:0]       skipped_count_reg, skipped_count_next;
    logic [POS_W-1:0] frame_pos_reg, frame_pos_next;
    logic [7:0]       sum_acc_reg, sum_acc_next;
    logic [8:0]       fail_count_reg, fail_count_next;
    logic [1:0]       fault_kind_reg, fault_kind_next;
    logic [7:0]       payload_reg [4];

    logic       fail;
    logic [1:0] fail_kind;
    logic [8:0] skip_inc;
    logic [8:0] fail_inc;
    logic       payload_we;

    always_comb
    begin
        in_frame_next      = in_frame_reg;
        prev_byte_next     = prev_byte_reg;
        skipped_count_next = skipped_count_reg;
        frame_pos_next     = frame_pos_reg;
        sum_acc_next       = sum_acc_reg;
        fail_count_next    = fail_count_reg;
        fault_kind_next    = fault_kind_reg;
        fail               = 1'b0;
        fail_kind          = FAULT_NONE;
        res_valid          = 1'b0;
        res.status         = STATUS_OK;
        res.range_value    = {payload_reg[1], payload_reg[0]};
        res.signal_level   = {payload_reg[3], payload_reg[2]};
        res.last_fault     = FAULT_NONE;
        skip_inc           = skipped_count_reg + 9'd1;
        fail_inc           = fail_count_reg + 9'd1;
        payload_we         = in_frame_reg && (frame_pos_reg < NUM_PAYLOAD);

        if (!in_frame_reg)
        begin
            if (prev_byte_reg == HDR_BYTE && rx_byte == HDR_BYTE)
            begin
                in_frame_next  = 1'b1;
                frame_pos_next = '0;
                sum_acc_next   = HDR_SUM;
            end
            else
            begin
                prev_byte_next     = rx_byte;
                skipped_count_next = skip_inc;
                if (skip_inc > {1'b0, cfg.max_skip_bytes})
                begin
                    fail      = 1'b1;
                    fail_kind = FAULT_NO_HEADER;
                end
            end
        end
        else if (frame_pos_reg < LAST_POS)
        begin
            sum_acc_next   = sum_acc_reg + rx_byte;
            frame_pos_next = frame_pos_reg + POS_W'(1);
        end
        else if (sum_acc_reg != rx_byte)
        begin
            fail      = 1'b1;
            fail_kind = FAULT_CHECKSUM;
        end
        else
        begin
            fault_kind_next    = FAULT_NONE;
            fail_count_next    = '0;
            in_frame_next      = 1'b0;
            prev_byte_next     = '0;
            skipped_count_next = '0;
            frame_pos_next     = '0;
            res_valid          = 1'b1;
        end

        if (fail)
        begin
            fault_kind_next    = fail_kind;
            in_frame_next      = 1'b0;
            prev_byte_next     = '0;
            skipped_count_next = '0;
            frame_pos_next     = '0;
            if (fail_inc > {1'b0, cfg.max_retries})
            begin
                fail_count_next  = '0;
                res_valid        = 1'b1;
                res.status       = STATUS_GAVE_UP;
                res.range_value  = 16'hFFFF;
                res.signal_level = 16'hFFFF;
                res.last_fault   = fail_kind;
            end
            else
            begin
                fail_count_next = fail_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg      <= 1'b0;
            prev_byte_reg     <= '0;
            skipped_count_reg <= '0;
            frame_pos_reg     <= '0;
            sum_acc_reg       <= '0;
            fail_count_reg    <= '0;
            fault_kind_reg    <= FAULT_NONE;
        end
        else if (step)
        begin
            in_frame_reg      <= in_frame_next;
            prev_byte_reg     <= prev_byte_next;
            skipped_count_reg <= skipped_count_next;
            frame_pos_reg     <= frame_pos_next;
            sum_acc_reg       <= sum_acc_next;
            fail_count_reg    <= fail_count_next;
            fault_kind_reg    <= fault_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && payload_we)
        begin
            payload_reg[frame_pos_reg[1:0]] <= rx_byte;
        end
    end

    a_result_restarts_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |=> !in_frame_reg && skipped_count_reg == 9'd0)
        else $error("hunt not restarted after result");

    a_good_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.status == STATUS_OK
        |=> fail_count_reg == 9'd0 && fault_kind_reg == FAULT_NONE)
        else $error("good frame did not clear failure state");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !skipped_count_reg[8] && !fail_count_reg[8])
        else $error("skip or failure count past limit range");

endmodule

FILE: hdl/lidar_frame_receiver.sv
// Top level: byte input register, frame parser and result output register.
//
//   channel  | dir | handshake        | payload
//   rx       | in  | valid / ready    | rx_byte
//   meas     | out | valid / ready    | status, range_value, signal_level, last_fault
//   cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// One byte per cycle unless meas stalls; the byte is registered, then its result.
// The parser works on the input register and writes the output register.
// A stalled result holds meas; one more byte is taken, then rx.ready drops.
// rst_n clears state and loads max_skip_bytes 30, max_retries 10.
module lidar_frame_receiver #(
    parameter int FRAME_LEN = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lfr_byte_if.sink                          rx,
    lfr_result_if.source                      meas,
    input  logic                              cfg_we,
    input  logic [lfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);
    import lfr_pkg::*;

    lfr_cfg_t    cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    lfr_result_t out_reg;
    logic        advance;
    logic        res_valid;
    lfr_result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || meas.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_skip_bytes <= MAX_SKIP_RESET;
            cfg_reg.max_retries    <= MAX_RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_SKIP:    cfg_reg.max_skip_bytes <= cfg_data;
                CFG_MAX_RETRIES: cfg_reg.max_retries    <= cfg_data;
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    lfr_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (meas.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign meas.valid        = out_valid_reg;
    assign meas.status       = out_reg.status;
    assign meas.range_value  = out_reg.range_value;
    assign meas.signal_level = out_reg.signal_level;
    assign meas.last_fault   = out_reg.last_fault;

    a_held_byte_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending byte lost while output stalled");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !meas.ready |-> !advance)
        else $error("parser stepped over an untaken result");

    a_giveup_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == STATUS_GAVE_UP
        |-> out_reg.range_value == 16'hFFFF && out_reg.last_fault != FAULT_NONE)
        else $error("give-up result malformed");

endmodule
